/* src/sorted_set_insert_delete_lookup_unit_defines.svh */
// ----------------------------------------------------------------------------
// sorted_set_insert_delete_lookup_unit_defines
// Assertion macros shared by the sorted set unit.
// Each macro takes a label, the clocked condition and a message.
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_INSERT_DELETE_LOOKUP_UNIT_DEFINES_SVH
`define SORTED_SET_INSERT_DELETE_LOOKUP_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SSET_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SSET_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Delayed implication, with the delay given by the n argument.
`define SSET_ASSERT_DELAY(lbl, ante, n, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

/* src/sset_pkg.sv */
// ----------------------------------------------------------------------------
// sset_pkg
// Types, codes and constants shared by the sorted set unit and its cells.
// ----------------------------------------------------------------------------
package sset_pkg;

	localparam int CAPACITY_DEF = 256;
	localparam int VAL_W        = 32;
	localparam int ENTRY_W      = 9;
	localparam int FOUND_GROUP  = 64;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CMP  = 4'b0010,
		S_RED  = 4'b0100,
		S_UPD  = 4'b1000
	} sset_state_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic                    cmp_en;
		logic                    ins_en;
		logic                    del_en;
		logic signed [VAL_W-1:0] key;
	} sset_ctl_t;

endpackage

/* src/sset_cell.sv */
// ----------------------------------------------------------------------------
// sset_cell
// One slot of the sorted chain: holds a value, compares it with the broadcast
// key and shifts toward or away from its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module sset_cell
	import sset_pkg::*;
#(
	parameter int IDX   = 0,
	parameter int CNT_W = 9
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sset_ctl_t               ctl,
	input  logic [CNT_W-1:0]        count,
	input  logic                    left_lt,
	input  logic signed [VAL_W-1:0] left_val,
	input  logic signed [VAL_W-1:0] right_val,
	output logic signed [VAL_W-1:0] val,
	output logic                    lt,
	output logic                    eq
);

	logic signed [VAL_W-1:0] val_q;
	logic                    lt_q;
	logic                    eq_q;
	logic                    occupied;

	assign occupied = count > CNT_W'(IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			lt_q <= occupied && (val_q < ctl.key);
			eq_q <= occupied && (val_q == ctl.key);
		end
	end

	// Cells below the insertion or deletion point keep their value.
	always_ff @(posedge clk) begin
		if (ctl.ins_en && !lt_q) begin
			val_q <= left_lt ? ctl.key : left_val;
		end else if (ctl.del_en && !lt_q) begin
			val_q <= right_val;
		end
	end

	assign val = val_q;
	assign lt  = lt_q;
	assign eq  = eq_q;

endmodule

/* src/sset_found_tree.sv */
// ----------------------------------------------------------------------------
// sset_found_tree
// Registered OR reduction of the per-cell match flags into one found bit.
// ----------------------------------------------------------------------------
module sset_found_tree
	import sset_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                clk,
	input  logic [CAPACITY-1:0] eq,
	output logic                found
);

	localparam int NUM_GROUPS = (CAPACITY + FOUND_GROUP - 1) / FOUND_GROUP;
	localparam int PAD_W      = NUM_GROUPS * FOUND_GROUP;

	logic [PAD_W-1:0]      eq_pad;
	logic [NUM_GROUPS-1:0] grp_q;

	assign eq_pad = PAD_W'(eq);

	always_ff @(posedge clk) begin
		for (int g = 0; g < NUM_GROUPS; g++) begin
			grp_q[g] <= |eq_pad[g*FOUND_GROUP +: FOUND_GROUP];
		end
	end

	assign found = |grp_q;

endmodule

/* src/sorted_set_insert_delete_lookup_unit.sv */
// ----------------------------------------------------------------------------
// sorted_set_insert_delete_lookup_unit
// Bounded table of signed values kept in ascending order in a chain of cells,
// with insert, delete and lookup commands.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      opcode, value
// result    out        done strobe, one cycle    status, entry_count
//
// A transaction steps through its states in order: accept latches the command,
// S_CMP registers each cell's compare flags, S_RED registers the grouped match
// flags of the found reduction, and S_UPD shifts the cells, updates the count
// and launches the result. S_RED is there for the registered found reduction.
// A new command may be accepted in the cycle in which done is high.
// Reset empties the table at once; the cell contents are never cleared.
// The receiver cannot stall the result, so busy depends on the command alone.
//
`include "sorted_set_insert_delete_lookup_unit_defines.svh"

module sorted_set_insert_delete_lookup_unit
	import sset_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] value,
	output logic               done,
	output logic [1:0]         status,
	output logic [8:0]         entry_count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	sset_state_t             state_q;
	logic [1:0]              op_q;
	logic signed [VAL_W-1:0] key_q;
	logic [CNT_W-1:0]        count_q;
	logic                    done_q;
	logic [1:0]              status_q;
	logic [ENTRY_W-1:0]      entry_count_q;

	sset_ctl_t               ctl;
	logic signed [VAL_W-1:0] cell_val [CAPACITY];
	logic [CAPACITY-1:0]     cell_lt;
	logic [CAPACITY-1:0]     cell_eq;
	logic                    found;
	logic                    full;
	logic                    accept;
	logic                    do_ins;
	logic                    do_del;
	logic [1:0]              stat_next;
	logic [CNT_W-1:0]        count_next;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign full   = (count_q == CNT_W'(CAPACITY));

	// The update happens only in the last cycle, and only when the
	// command really changes the table.
	assign do_ins = (state_q == S_UPD) && (op_q == OP_INSERT) && !full;
	assign do_del = (state_q == S_UPD) && (op_q == OP_DELETE) && found;

	always_comb begin
		ctl.cmp_en = (state_q == S_CMP);
		ctl.ins_en = do_ins;
		ctl.del_en = do_del;
		ctl.key    = key_q;
	end

	always_comb begin
		case (op_q) inside
			OP_INSERT: stat_next = full ? STAT_FULL : STAT_OK;
			OP_DELETE,
			OP_LOOKUP: stat_next = found ? STAT_OK : STAT_NOT_FOUND;
			default:   stat_next = STAT_NOT_FOUND;
		endcase
	end

	always_comb begin
		if (do_ins) begin
			count_next = CNT_W'(count_q + 1'b1);
		end else if (do_del) begin
			count_next = CNT_W'(count_q - 1'b1);
		end else begin
			count_next = count_q;
		end
	end

	// Command sequencer: accept, compare, reduce, update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: state_q <= S_RED;
				S_RED: state_q <= S_UPD;
				S_UPD: begin
					state_q <= S_IDLE;
					count_q <= count_next;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode;
			key_q <= value;
		end
		if (state_q == S_UPD) begin
			status_q      <= stat_next;
			entry_count_q <= ENTRY_W'(count_next);
		end
	end

	// The chain: each cell sees its left neighbor's compare flag and value
	// for insert, and its right neighbor's value for delete. The left edge
	// acts as a smaller entry, so an insert at the head takes the key.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                    left_lt;
		logic signed [VAL_W-1:0] left_val;
		logic signed [VAL_W-1:0] right_val;

		if (i == 0) begin : g_head
			assign left_lt  = 1'b1;
			assign left_val = '0;
		end else begin : g_body
			assign left_lt  = cell_lt[i-1];
			assign left_val = cell_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_val = '0;
		end else begin : g_next
			assign right_val = cell_val[i+1];
		end

		sset_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.count     (count_q),
			.left_lt   (left_lt),
			.left_val  (left_val),
			.right_val (right_val),
			.val       (cell_val[i]),
			.lt        (cell_lt[i]),
			.eq        (cell_eq[i])
		);
	end

	sset_found_tree #(
		.CAPACITY (CAPACITY)
	) u_found (
		.clk   (clk),
		.eq    (cell_eq),
		.found (found)
	);

	assign done        = done_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

	// The count never passes the capacity of the chain.
	`SSET_ASSERT_IMPL(a_count_cap, 1'b1, count_q <= CNT_W'(CAPACITY), "count above capacity")
	// Every accepted transaction is followed by its result strobe.
	`SSET_ASSERT_DELAY(a_latency, accept, 4, done_q, "result strobe missing")
	// The count moves only in the update cycle.
	`SSET_ASSERT_NEXT(a_count_upd, state_q != S_UPD, $stable(count_q), "count changed off update")
	// A full report leaves the table full.
	`SSET_ASSERT_IMPL(a_full_rep, done_q && status_q == STAT_FULL, full, "full on non-full table")
	// A result is shown only once the sequencer is idle again.
	`SSET_ASSERT_IMPL(a_done_idle, done_q, state_q == S_IDLE, "result while busy")

endmodule
